// ===== hdl/lkv_pkg.sv =====
// Shared types and constants for the LRU key/value cache.
package lkv_pkg;

   localparam int DATA_W    = 32;
   localparam int CAP_W     = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_READ,
      ST_COMMIT
   } state_type;

   typedef enum logic {
      ACT_GET = 1'b0,
      ACT_PUT = 1'b1
   } action_type;

   typedef struct packed {
      logic capture;
      logic scan;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic out_busy;
   } stat_type;

endpackage

// ===== hdl/lkv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lkv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/lkv_ctrl.sv =====
// Request sequencer: capture, key scan, value read, commit.
module lkv_ctrl
   import lkv_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (stat.scan_last) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (!stat.out_busy) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.scan    = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // drop ready while reset is held
            req_ready   = !reset;
            cmd.capture = req_valid && !reset;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_READ: begin
         end
         ST_COMMIT: begin
            // hold until the result register is free
            cmd.commit = !stat.out_busy;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== hdl/lkv_datapath.sv =====
// Entry store, recency ranks, scan trackers and result register.
module lkv_datapath
   import lkv_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  logic              req_action,
   input  logic [DATA_W-1:0] req_key,
   input  logic [DATA_W-1:0] req_value,
   input  logic              csr_write,
   input  logic [CAP_W-1:0]  csr_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_found,
   output logic [DATA_W-1:0] rsp_read_value
);

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int RANK_W = IDX_W;
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   // request
   logic              action_ff;
   logic [DATA_W-1:0] key_ff;
   logic [DATA_W-1:0] value_ff;

   // scan trackers
   logic [CNT_W-1:0]  cnt_ff;
   logic              hit_ff;
   logic [IDX_W-1:0]  hit_idx_ff;
   logic [RANK_W-1:0] hit_rank_ff;
   logic              free_ff;
   logic [IDX_W-1:0]  free_idx_ff;
   logic [IDX_W-1:0]  vict_idx_ff;

   // entry state
   logic              valid_ff [ENTRIES];
   logic [RANK_W-1:0] rank_ff  [ENTRIES];
   logic [CNT_W-1:0]  used_ff;
   logic [CAP_W-1:0]  cap_ff;

   // result register
   logic              rsp_valid_ff;
   logic              rsp_found_ff;
   logic [DATA_W-1:0] rsp_value_ff;

   logic [DATA_W-1:0] key_rd;
   logic [DATA_W-1:0] val_rd;
   logic [IDX_W-1:0]  key_rd_addr;
   logic [IDX_W-1:0]  cmp_idx;
   logic [CNT_W-1:0]  used_m1;
   logic [RANK_W-1:0] lru_rank;
   logic              scan_eval;
   logic              scan_match;
   logic              scan_free;
   logic              scan_lru;
   logic              is_put;
   logic              have_free;
   logic              rank_upd;
   logic              age_all;
   logic              fill;
   logic [IDX_W-1:0]  slot;
   logic [RANK_W-1:0] promo_rank;

   assign is_put      = (action_ff == ACT_PUT);
   assign key_rd_addr = (cnt_ff == CNT_W'(ENTRIES)) ? '0 : cnt_ff[IDX_W-1:0];
   assign cmp_idx     = IDX_W'(cnt_ff - CNT_W'(1));
   assign used_m1     = used_ff - CNT_W'(1);
   assign lru_rank    = used_m1[RANK_W-1:0];

   // registered read data for index cnt-1 arrives in the cycle after its address
   assign scan_eval  = cmd.scan && (cnt_ff != '0);
   assign scan_match = scan_eval && valid_ff[cmp_idx] && (key_rd == key_ff);
   assign scan_free  = scan_eval && !valid_ff[cmp_idx];
   assign scan_lru   = scan_eval && valid_ff[cmp_idx] && (rank_ff[cmp_idx] == lru_rank);

   // capacity zero acts as one; a free slot exists only below ENTRIES
   assign have_free = free_ff &&
                      ((CMP_W'(cap_ff) > CMP_W'(used_ff)) || (used_ff == '0));

   always_comb begin
      slot       = hit_idx_ff;
      promo_rank = hit_rank_ff;
      age_all    = 1'b0;
      fill       = 1'b0;
      rank_upd   = cmd.commit && (hit_ff || is_put);
      if (!hit_ff) begin
         if (have_free) begin
            slot    = free_idx_ff;
            age_all = 1'b1;
            fill    = 1'b1;
         end else begin
            slot       = vict_idx_ff;
            promo_rank = lru_rank;
         end
      end
   end

   lkv_ram #(
      .WIDTH (DATA_W),
      .DEPTH (ENTRIES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && is_put),
      .wr_addr (slot),
      .wr_data (key_ff),
      .rd_addr (key_rd_addr),
      .rd_data (key_rd)
   );

   lkv_ram #(
      .WIDTH (DATA_W),
      .DEPTH (ENTRIES)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && is_put),
      .wr_addr (slot),
      .wr_data (value_ff),
      .rd_addr (hit_idx_ff),
      .rd_data (val_rd)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         key_ff    <= req_key;
         value_ff  <= req_value;
      end
      if (scan_match && !hit_ff) begin
         hit_idx_ff  <= cmp_idx;
         hit_rank_ff <= rank_ff[cmp_idx];
      end
      if (scan_free && !free_ff) begin
         free_idx_ff <= cmp_idx;
      end
      if (scan_lru) begin
         vict_idx_ff <= cmp_idx;
      end
      if (cmd.commit) begin
         rsp_found_ff <= hit_ff;
         rsp_value_ff <= (hit_ff && !is_put) ? val_rd : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (cmd.capture) begin
         cnt_ff  <= '0;
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (cmd.scan) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (scan_match) hit_ff <= 1'b1;
         if (scan_free) free_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
            rank_ff[i]  <= '0;
         end
         used_ff <= '0;
      end else if (rank_upd) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (IDX_W'(i) == slot) begin
               rank_ff[i] <= '0;
               if (fill) valid_ff[i] <= 1'b1;
            end else if (valid_ff[i] && (age_all || (rank_ff[i] < promo_rank))) begin
               rank_ff[i] <= rank_ff[i] + RANK_W'(1);
            end
         end
         if (fill) used_ff <= used_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) cap_ff <= csr_data;
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.scan_last = cmd.scan && (cnt_ff == CNT_W'(ENTRIES));
   assign stat.out_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_read_value = rsp_value_ff;

endmodule

// ===== hdl/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key/value cache.
//
//  channel  ports                         direction  transaction
//  req      req_valid/ready, action,key,value  in    one get or put
//  rsp      rsp_valid/ready, found,read_value  out   one result per request
//  csr      csr_valid/ready, csr_data      in        capacity write
//
// After a request is accepted, the key scan walks all ENTRIES entries
// through the key RAM read port (one entry per cycle); then follow one
// value RAM read and one commit, which loads the result register.
// One request is in flight at a time; the next is accepted in the cycle
// after the previous result is loaded into the result register.
// A stalled result holds the commit until the result register frees.
// Reset is synchronous: the store is empty and capacity returns to 16.
module lru_key_value_cache
   import lkv_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_action,
   input  logic [DATA_W-1:0] req_key,
   input  logic [DATA_W-1:0] req_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_found,
   output logic [DATA_W-1:0] rsp_read_value,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CAP_W-1:0]  csr_data
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = !reset;

   lkv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lkv_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_action     (req_action),
      .req_key        (req_key),
      .req_value      (req_value),
      .csr_write      (csr_valid && csr_ready),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_found      (rsp_found),
      .rsp_read_value (rsp_read_value)
   );

   // one transaction at a time: no accept right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous one in flight");

   // never overwrite a result still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid && !rsp_ready))
      else $error("commit while result register busy");

   // misses carry a zero value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_read_value == '0))
      else $error("miss result with nonzero value");

   // scan stops after the last entry
   assert property (@(posedge clock) disable iff (reset)
      stat.scan_last |=> !cmd.scan)
      else $error("scan ran past the last entry");

endmodule
